[hdl/gma_pkg.sv]
// Shared types and constants for the gated moving average block.
package gma_pkg;

  localparam int SPEED_BITS     = 16;
  localparam int MAX_WINDOW_DEF = 20;
  localparam int WIN_W          = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int USED_W         = 5;

  localparam logic [WIN_W-1:0] WINDOW_RESET_5 = WIN_W'(5);
  localparam logic signed [SPEED_BITS-1:0] LOW_RESET  = '0;
  localparam logic signed [SPEED_BITS-1:0] HIGH_RESET = SPEED_BITS'(19200);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_LOW    = 2'd1,
    CFG_HIGH   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic                         cmd;
    logic signed [SPEED_BITS-1:0] speed_sample;
  } in_word_t;

  typedef struct packed {
    logic                         is_abnormal;
    logic signed [SPEED_BITS-1:0] speed_value;
    logic [USED_W-1:0]            samples_used;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic store;
    logic sum_step;
    logic div_start;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_abnormal;
    logic sum_done;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/gma_ctrl.sv]
// Controller state machine sequencing store, sum, divide and emit.
module gma_ctrl
  import gma_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctl_state_e state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !stat_i.in_clear) begin
          state_d = stat_i.in_abnormal ? ST_EMIT : ST_SUM;
        end
      end
      ST_SUM: begin
        if (stat_i.sum_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = accept;
        cmd_o.clear   = accept && stat_i.in_clear;
        cmd_o.store   = accept && !stat_i.in_clear && !stat_i.in_abnormal;
      end
      ST_SUM: begin
        cmd_o.sum_step  = 1'b1;
        cmd_o.div_start = stat_i.sum_done;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

[hdl/gma_datapath.sv]
// Datapath: config registers, sample ring, accumulator, divider, result register.
module gma_datapath
  import gma_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_word_t              in_word_i,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o
);

  localparam int SB    = SPEED_BITS;
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUMW  = SB + CW;
  localparam int DCW   = $clog2(SUMW + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);
  localparam logic [WIN_W-1:0] WINDOW_RESET =
    (MAX_WINDOW < 5) ? WIN_W'(MAX_WINDOW) : WINDOW_RESET_5;

  logic [WIN_W-1:0]       window_q;
  logic signed [SB-1:0]   low_q, high_q;
  logic [AW-1:0]          slot_q, slot_next;
  logic [CW-1:0]          count_q, count_next;
  logic signed [SB-1:0]   mem [MAX_WINDOW];
  logic [AW-1:0]          rd_ptr_q, rd_prev;
  logic [CW-1:0]          rd_left_q;
  logic                   rd_en;
  logic                   rd_vld_q;
  logic [SB-1:0]          rd_data_q;
  logic [SUMW-1:0]        acc_q;
  logic [SUMW-1:0]        quo_q;
  logic [CW-1:0]          rem_q;
  logic [CW:0]            rem_shift;
  logic                   rem_ge;
  logic [DCW-1:0]         div_cnt_q;
  logic                   neg_q;
  logic signed [SB-1:0]   raw_q;
  logic                   abn_q;
  logic [SUMW-1:0]        quo_signed;
  logic [WIN_W-1:0]       cfg_win;
  logic                   cfg_win_ok;
  logic                   in_abn;
  logic                   out_valid_q;
  out_word_t              out_word_q;

  assign in_abn = (in_word_i.speed_sample < low_q) || (in_word_i.speed_sample > high_q);

  assign stat_o.in_clear    = (in_word_i.cmd == CMD_CLEAR);
  assign stat_o.in_abnormal = in_abn;
  assign stat_o.sum_done    = (rd_left_q == '0) && !rd_vld_q;
  assign stat_o.div_done    = (div_cnt_q == '0);
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  assign cfg_win    = cfg_data_i[WIN_W-1:0];
  assign cfg_win_ok = (cfg_win != '0) && (32'(cfg_win) <= MAX_WINDOW);

  assign slot_next  = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
  assign count_next = (32'(count_q) < 32'(window_q)) ? count_q + 1'b1 : count_q;
  assign rd_prev    = (rd_ptr_q == '0) ? LAST_SLOT : rd_ptr_q - 1'b1;
  assign rd_en      = cmd_i.sum_step && (rd_left_q != '0);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      low_q    <= LOW_RESET;
      high_q   <= HIGH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW: if (cfg_win_ok) window_q <= cfg_win;
        CFG_LOW:    low_q  <= cfg_data_i[SB-1:0];
        CFG_HIGH:   high_q <= cfg_data_i[SB-1:0];
        default:    ;
      endcase
    end
  end

  // Ring pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.clear) begin
      slot_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.store) begin
      slot_q  <= slot_next;
      count_q <= count_next;
    end else if (cfg_we_i && (cfg_idx_i == CFG_WINDOW) && cfg_win_ok &&
                 (32'(count_q) > 32'(cfg_win))) begin
      count_q <= CW'(cfg_win);
    end
  end

  // Sample ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[slot_q] <= in_word_i.speed_sample;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_prev];
    end
  end

  // Walk back from the newest entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      rd_left_q <= '0;
      rd_vld_q  <= 1'b0;
    end else if (cmd_i.store) begin
      rd_ptr_q  <= slot_next;
      rd_left_q <= count_next;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (rd_en) begin
        rd_ptr_q  <= rd_prev;
        rd_left_q <= rd_left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      acc_q <= '0;
    end else if (rd_vld_q) begin
      acc_q <= acc_q + {{CW{rd_data_q[SB-1]}}, rd_data_q};
    end
  end

  // Restoring divide of |sum| by the fill count
  assign rem_shift = {rem_q, quo_q[SUMW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, count_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= DCW'(SUMW);
    end else if (cmd_i.div_step && (div_cnt_q != '0)) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= acc_q[SUMW-1];
      quo_q <= acc_q[SUMW-1] ? (~acc_q + 1'b1) : acc_q;
      rem_q <= '0;
    end else if (cmd_i.div_step && (div_cnt_q != '0)) begin
      rem_q <= rem_ge ? CW'(rem_shift - {1'b0, count_q}) : rem_shift[CW-1:0];
      quo_q <= {quo_q[SUMW-2:0], rem_ge};
    end
  end

  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      raw_q <= in_word_i.speed_sample;
      abn_q <= in_abn;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_word_q.is_abnormal  <= abn_q;
      out_word_q.speed_value  <= abn_q ? raw_q : quo_signed[SB-1:0];
      out_word_q.samples_used <= abn_q ? '0 : USED_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[hdl/gated_moving_average.sv]
// Top level of the range-gated moving average of speed samples.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o | cmd, speed_sample
//  out     | output    | out_valid_o/out_stall_i | is_abnormal, speed_value, samples_used
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A sample word is summed, then divided by the fill count:
// one ring read per sample in the window, then one quotient bit per cycle in the divider.
// An out-of-range sample goes straight to emit, and a clear leaves the block idle.
// Reset empties the ring pointer and count and loads the register reset values.
// The next word is taken while a finished result waits on out_stall_i.
module gated_moving_average
  import gma_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gma_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTHESIS
  a_clear_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && stat.in_clear) |=> !in_stall_o)
    else $error("clear word left the block busy");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !stat.in_clear) |=> in_stall_o)
    else $error("sample word did not start work");

  a_emit_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("result emitted over a held word");

  a_start_after_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> (stat.sum_done && !cmd.store))
    else $error("divide started before the sum finished");
`endif

endmodule
